// File: sv/slxfr_pkg.sv
// Shared types and constants for the sync/length/XOR frame receiver.
// Used by slxfr_cmd_fifo, slxfr_front, slxfr_back and the top level; depends on nothing.
package slxfr_pkg;

    localparam int FRAME_BUFFER_BYTES = 32;
    localparam int FRAME_OVERHEAD = 4;
    localparam int BYTE_W = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CMD_FIFO_DEPTH = 2;

    localparam logic [BYTE_W-1:0] SYNC_FIRST_RESET = 8'h06;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RESET = 8'h85;

    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_FIRST = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_SECOND = 2'd1;

    typedef enum logic [1:0] {
        ST_PAYLOAD = 2'd0,
        ST_BADSUM = 2'd1,
        ST_TOOLONG = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        PH_FIRST = 2'd0,
        PH_SECOND = 2'd1,
        PH_LENGTH = 2'd2,
        PH_BODY = 2'd3
    } phase_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_EMIT = 1'b1
    } back_state_t;

    typedef struct packed {
        status_t kind;
        logic [BYTE_W-1:0] count;
    } cmd_t;

endpackage

// File: sv/slxfr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module slxfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 28
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/slxfr_cmd_fifo.sv
// Short request queue between the frame parser and the result sequencer.
// Depends on slxfr_pkg for the request type and queue depth.
module slxfr_cmd_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  slxfr_pkg::cmd_t   wr_cmd,
    output logic              full,
    input  logic              rd_en,
    output slxfr_pkg::cmd_t   rd_cmd,
    output logic              empty
);

    localparam int PW = $clog2(slxfr_pkg::CMD_FIFO_DEPTH);
    localparam int CW = $clog2(slxfr_pkg::CMD_FIFO_DEPTH + 1);

    slxfr_pkg::cmd_t entry_reg [slxfr_pkg::CMD_FIFO_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic do_wr, do_rd;

    assign full = (count_reg == CW'(slxfr_pkg::CMD_FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;
    assign rd_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = PW'((CW'(wr_ptr_reg) + CW'(1)) % CW'(slxfr_pkg::CMD_FIFO_DEPTH));
        end
        if (do_rd)
        begin
            rd_ptr_next = PW'((CW'(rd_ptr_reg) + CW'(1)) % CW'(slxfr_pkg::CMD_FIFO_DEPTH));
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

// File: sv/slxfr_front.sv
// Frame parser: sync hunt, length check, body capture into RAM and checksum.
// Depends on slxfr_pkg; issues requests to the queue in front of slxfr_back.
module slxfr_front #(
    parameter int FRAME_BUFFER_BYTES = slxfr_pkg::FRAME_BUFFER_BYTES,
    localparam int BODY_DEPTH = FRAME_BUFFER_BYTES - slxfr_pkg::FRAME_OVERHEAD,
    localparam int AW = $clog2(BODY_DEPTH)
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic [slxfr_pkg::BYTE_W-1:0]         rx_byte,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [slxfr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [slxfr_pkg::BYTE_W-1:0]         cfg_data,
    output logic                                 cmd_wr,
    output slxfr_pkg::cmd_t                      cmd,
    input  logic                                 cmd_full,
    input  logic                                 burst_done,
    output logic                                 mem_wr_en,
    output logic [AW-1:0]                        mem_wr_addr,
    output logic [slxfr_pkg::BYTE_W-1:0]         mem_wr_data
);

    localparam int LW = slxfr_pkg::BYTE_W + 1;

    slxfr_pkg::phase_t phase_reg, phase_next;
    logic [slxfr_pkg::BYTE_W-1:0] sync_first_reg, sync_second_reg;
    logic [slxfr_pkg::BYTE_W-1:0] len_reg, len_next;
    logic [slxfr_pkg::BYTE_W-1:0] count_reg, count_next;
    logic [slxfr_pkg::BYTE_W-1:0] csum_reg, csum_next;
    logic pend_reg, pend_next;
    logic accept;
    logic too_long;

    assign full = pend_reg || cmd_full;
    assign accept = push && !full;
    assign cfg_ready = 1'b1;
    assign too_long = ({1'b0, rx_byte} > LW'(BODY_DEPTH));

    always_comb
    begin
        phase_next = phase_reg;
        len_next = len_reg;
        count_next = count_reg;
        csum_next = csum_reg;
        if (accept)
        begin
            case (phase_reg)
                slxfr_pkg::PH_FIRST:
                begin
                    if (rx_byte == sync_first_reg)
                    begin
                        phase_next = slxfr_pkg::PH_SECOND;
                    end
                end
                slxfr_pkg::PH_SECOND:
                begin
                    phase_next = (rx_byte == sync_second_reg) ? slxfr_pkg::PH_LENGTH
                                                              : slxfr_pkg::PH_FIRST;
                end
                slxfr_pkg::PH_LENGTH:
                begin
                    if (rx_byte == '0 || too_long)
                    begin
                        phase_next = slxfr_pkg::PH_FIRST;
                    end
                    else
                    begin
                        len_next = rx_byte;
                        count_next = '0;
                        csum_next = rx_byte;
                        phase_next = slxfr_pkg::PH_BODY;
                    end
                end
                slxfr_pkg::PH_BODY:
                begin
                    if (count_reg < len_reg)
                    begin
                        csum_next = csum_reg ^ rx_byte;
                        count_next = count_reg + 8'd1;
                    end
                    else
                    begin
                        phase_next = slxfr_pkg::PH_FIRST;
                    end
                end
                default:
                begin
                    phase_next = slxfr_pkg::PH_FIRST;
                end
            endcase
        end
    end

    always_comb
    begin
        cmd_wr = 1'b0;
        cmd.kind = slxfr_pkg::ST_PAYLOAD;
        cmd.count = count_reg;
        mem_wr_en = 1'b0;
        mem_wr_addr = count_reg[AW-1:0];
        mem_wr_data = rx_byte;
        pend_next = pend_reg && !burst_done;
        if (accept)
        begin
            case (phase_reg)
                slxfr_pkg::PH_LENGTH:
                begin
                    if (rx_byte != '0 && too_long)
                    begin
                        cmd_wr = 1'b1;
                        cmd.kind = slxfr_pkg::ST_TOOLONG;
                    end
                end
                slxfr_pkg::PH_BODY:
                begin
                    if (count_reg < len_reg)
                    begin
                        mem_wr_en = 1'b1;
                    end
                    else if (csum_reg != rx_byte)
                    begin
                        cmd_wr = 1'b1;
                        cmd.kind = slxfr_pkg::ST_BADSUM;
                    end
                    else
                    begin
                        cmd_wr = 1'b1;
                        cmd.kind = slxfr_pkg::ST_PAYLOAD;
                        pend_next = 1'b1;
                    end
                end
                default:
                begin
                    cmd_wr = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= slxfr_pkg::PH_FIRST;
            len_reg <= '0;
            count_reg <= '0;
            csum_reg <= '0;
            pend_reg <= 1'b0;
            sync_first_reg <= slxfr_pkg::SYNC_FIRST_RESET;
            sync_second_reg <= slxfr_pkg::SYNC_SECOND_RESET;
        end
        else
        begin
            phase_reg <= phase_next;
            len_reg <= len_next;
            count_reg <= count_next;
            csum_reg <= csum_next;
            pend_reg <= pend_next;
            if (cfg_valid && cfg_index == slxfr_pkg::CFG_SYNC_FIRST)
            begin
                sync_first_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == slxfr_pkg::CFG_SYNC_SECOND)
            begin
                sync_second_reg <= cfg_data;
            end
        end
    end

endmodule

// File: sv/slxfr_back.sv
// Result sequencer: turns queued requests into result items, reading frame bodies from RAM.
// Depends on slxfr_pkg; reads the body RAM written by slxfr_front.
module slxfr_back #(
    parameter int FRAME_BUFFER_BYTES = slxfr_pkg::FRAME_BUFFER_BYTES,
    localparam int BODY_DEPTH = FRAME_BUFFER_BYTES - slxfr_pkg::FRAME_OVERHEAD,
    localparam int AW = $clog2(BODY_DEPTH)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_empty,
    input  slxfr_pkg::cmd_t               cmd,
    output logic                          cmd_rd,
    output logic                          burst_done,
    output logic                          mem_rd_en,
    output logic [AW-1:0]                 mem_rd_addr,
    input  logic [slxfr_pkg::BYTE_W-1:0]  mem_rd_data,
    output logic                          empty,
    input  logic                          pop,
    output logic [1:0]                    status,
    output logic                          is_command,
    output logic [slxfr_pkg::BYTE_W-1:0]  byte_value,
    output logic                          last
);

    slxfr_pkg::back_state_t state_reg, state_next;
    logic [slxfr_pkg::BYTE_W-1:0] idx_reg, idx_next;
    logic [slxfr_pkg::BYTE_W-1:0] cnt_reg, cnt_next;
    logic out_valid_reg, out_valid_next;
    slxfr_pkg::status_t status_reg, status_next;
    logic is_command_reg, is_command_next;
    logic [slxfr_pkg::BYTE_W-1:0] byte_value_reg, byte_value_next;
    logic last_reg, last_next;
    logic out_free;
    logic at_last;

    assign out_free = !out_valid_reg || pop;
    assign at_last = (idx_reg + 8'd1 == cnt_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            slxfr_pkg::BK_IDLE:
            begin
                if (!cmd_empty && cmd.kind == slxfr_pkg::ST_PAYLOAD)
                begin
                    state_next = slxfr_pkg::BK_EMIT;
                end
            end
            slxfr_pkg::BK_EMIT:
            begin
                if (out_free && at_last)
                begin
                    state_next = slxfr_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = slxfr_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_rd = 1'b0;
        burst_done = 1'b0;
        mem_rd_en = 1'b0;
        mem_rd_addr = idx_reg[AW-1:0];
        idx_next = idx_reg;
        cnt_next = cnt_reg;
        out_valid_next = out_valid_reg && !pop;
        status_next = status_reg;
        is_command_next = is_command_reg;
        byte_value_next = byte_value_reg;
        last_next = last_reg;
        case (state_reg)
            slxfr_pkg::BK_IDLE:
            begin
                if (!cmd_empty && cmd.kind == slxfr_pkg::ST_PAYLOAD)
                begin
                    cmd_rd = 1'b1;
                    mem_rd_en = 1'b1;
                    mem_rd_addr = '0;
                    idx_next = '0;
                    cnt_next = cmd.count;
                end
                else if (!cmd_empty && out_free)
                begin
                    cmd_rd = 1'b1;
                    out_valid_next = 1'b1;
                    status_next = cmd.kind;
                    is_command_next = 1'b0;
                    byte_value_next = '0;
                    last_next = 1'b1;
                end
            end
            slxfr_pkg::BK_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next = slxfr_pkg::ST_PAYLOAD;
                    is_command_next = (idx_reg == '0);
                    byte_value_next = mem_rd_data;
                    last_next = at_last;
                    if (at_last)
                    begin
                        burst_done = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + 8'd1;
                        mem_rd_en = 1'b1;
                        mem_rd_addr = idx_next[AW-1:0];
                    end
                end
            end
            default:
            begin
                cmd_rd = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= slxfr_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
            idx_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            idx_reg <= idx_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        is_command_reg <= is_command_next;
        byte_value_reg <= byte_value_next;
        last_reg <= last_next;
    end

    assign empty = !out_valid_reg;
    assign status = status_reg;
    assign is_command = is_command_reg;
    assign byte_value = byte_value_reg;
    assign last = last_reg;

endmodule

// File: sv/sync_length_xor_frame_receiver_top.sv
// Top level of the sync/length/XOR frame receiver: parser, request queue, body RAM, sequencer.
// Depends on slxfr_pkg, slxfr_front, slxfr_cmd_fifo, slxfr_ram and slxfr_back.
//
// Received bytes are pushed one per cycle while full is low; the parser hunts for the two
// sync bytes, takes a nonzero length of at most FRAME_BUFFER_BYTES-4, stores the body in a
// RAM and checks the XOR checksum. Error results are queued as requests and the parser keeps
// accepting bytes until two of them wait. After the checksum byte of a good frame, full
// stays high until the sequencer has read all L body bytes back out of the RAM, one per
// cycle while pop is held. Configuration writes are always taken.
module sync_length_xor_frame_receiver_top #(
    parameter int FRAME_BUFFER_BYTES = slxfr_pkg::FRAME_BUFFER_BYTES
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic [7:0]                         rx_byte,
    output logic                               empty,
    input  logic                               pop,
    output logic [1:0]                         status,
    output logic                               is_command,
    output logic [7:0]                         byte_value,
    output logic                               last,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [slxfr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [7:0]                         cfg_data
);

    localparam int BODY_DEPTH = FRAME_BUFFER_BYTES - slxfr_pkg::FRAME_OVERHEAD;
    localparam int AW = $clog2(BODY_DEPTH);

    slxfr_pkg::cmd_t wr_cmd, rd_cmd;
    logic cmd_wr, cmd_rd, cmd_full, cmd_empty;
    logic burst_done;
    logic mem_wr_en, mem_rd_en;
    logic [AW-1:0] mem_wr_addr, mem_rd_addr;
    logic [7:0] mem_wr_data, mem_rd_data;

    slxfr_front #(
        .FRAME_BUFFER_BYTES(FRAME_BUFFER_BYTES)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .rx_byte(rx_byte),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .cmd_wr(cmd_wr),
        .cmd(wr_cmd),
        .cmd_full(cmd_full),
        .burst_done(burst_done),
        .mem_wr_en(mem_wr_en),
        .mem_wr_addr(mem_wr_addr),
        .mem_wr_data(mem_wr_data)
    );

    slxfr_cmd_fifo u_cmd_fifo (
        .clk(clk),
        .rst_n(rst_n),
        .wr_en(cmd_wr),
        .wr_cmd(wr_cmd),
        .full(cmd_full),
        .rd_en(cmd_rd),
        .rd_cmd(rd_cmd),
        .empty(cmd_empty)
    );

    slxfr_ram #(
        .WIDTH(slxfr_pkg::BYTE_W),
        .DEPTH(BODY_DEPTH)
    ) u_body_ram (
        .clk(clk),
        .wr_en(mem_wr_en),
        .wr_addr(mem_wr_addr),
        .wr_data(mem_wr_data),
        .rd_en(mem_rd_en),
        .rd_addr(mem_rd_addr),
        .rd_data(mem_rd_data)
    );

    slxfr_back #(
        .FRAME_BUFFER_BYTES(FRAME_BUFFER_BYTES)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_empty(cmd_empty),
        .cmd(rd_cmd),
        .cmd_rd(cmd_rd),
        .burst_done(burst_done),
        .mem_rd_en(mem_rd_en),
        .mem_rd_addr(mem_rd_addr),
        .mem_rd_data(mem_rd_data),
        .empty(empty),
        .pop(pop),
        .status(status),
        .is_command(is_command),
        .byte_value(byte_value),
        .last(last)
    );

endmodule
